@@ hw/rtl/afu_pkg.sv @@
package afu_pkg;

    // Sample format and fixed-point layout
    localparam int DATA_W        = 24;
    localparam int FRAC_BITS     = 16;
    localparam int TABLE_ENTRIES = 256;

    // Register widths and reset values
    localparam int FSEL_W            = 3;
    localparam int LEAK_W            = 16;
    localparam int LEAK_FRAC         = 16;
    localparam int SIG_SCALE_W       = 23;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 24;
    localparam int SIG_SCALE_RESET   = 65536;
    localparam int TANH_SCALE_RESET  = 65536;

    // Pipeline depth, input register through output register
    localparam int STAGES = 6;

    // Derived widths
    localparam int TAB_W       = FRAC_BITS + 1;
    localparam int IDX_W       = $clog2(TABLE_ENTRIES + 1);
    localparam int MAG_W       = DATA_W;
    localparam int PIDX_W      = MAG_W + $clog2(TABLE_ENTRIES + 1);
    localparam int SPAN_SHIFT  = FRAC_BITS + 3;
    localparam int REM_W       = SPAN_SHIFT;
    localparam int IP_W        = TAB_W + REM_W + 1;
    localparam int M1_W        = 2 * TAB_W;
    localparam int OP_W        = (DATA_W > FRAC_BITS + 2) ? DATA_W : FRAC_BITS + 2;
    localparam int COEF_W      = DATA_W + 1;
    localparam int PROD_W      = OP_W + COEF_W;
    localparam int Y_W         = PROD_W + 1;

    typedef enum logic [FSEL_W-1:0] {
        FN_RELU        = 3'd0,
        FN_RELU_GRAD   = 3'd1,
        FN_SIGMOID     = 3'd2,
        FN_SIGMOID_GRAD = 3'd3,
        FN_TANH        = 3'd4,
        FN_TANH_GRAD   = 3'd5
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FUNCTION_SELECT = 2'd0,
        REG_LEAK_WEIGHT     = 2'd1,
        REG_SIGMOID_SCALE   = 2'd2,
        REG_TANH_SCALE      = 2'd3
    } cfg_reg_t;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [PIDX_W-1:0]        pidx_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [IP_W-1:0]          ip_t;
    typedef logic [M1_W-1:0]          m1_t;
    typedef logic signed [OP_W-1:0]   op_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [Y_W-1:0]    y_t;
    typedef logic [TAB_W-1:0]         tab_entry_t;
    typedef tab_entry_t [TABLE_ENTRIES:0] tab_t;

    // One table row as seen by the interpolation stage
    typedef struct packed {
        tab_entry_t lo;
        tab_entry_t diff;
        rem_t       rem;
    } lut_row_t;

    localparam data_t      DATA_MAX    = data_t'(2**(DATA_W-1) - 1);
    localparam data_t      DATA_MIN    = data_t'(-(2**(DATA_W-1)));
    localparam tab_entry_t TAB_ONE     = tab_entry_t'(1) << FRAC_BITS;
    localparam ip_t        IP_HALF     = ip_t'(1) << (SPAN_SHIFT - 1);
    localparam m1_t        M1_HALF     = m1_t'(1) << (FRAC_BITS - 1);
    localparam op_t        OP_ONE      = op_t'(1) << FRAC_BITS;
    localparam y_t         Y_ONE       = y_t'(1) << FRAC_BITS;
    localparam y_t         Y_HALF_LEAK = y_t'(1) << (LEAK_FRAC - 1);
    localparam y_t         Y_HALF_FRAC = y_t'(1) << (FRAC_BITS - 1);
    localparam y_t         Y_MAX       = y_t'(2**(DATA_W-1) - 1);
    localparam y_t         Y_MIN       = y_t'(-(2**(DATA_W-1)));

    // Restoring divide, used only while building the constant tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // (a*b) >> 60 for operands below 2^62, truncating
    function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
        ah  = a >> 32;
        al  = {32'd0, a[31:0]};
        bh  = b >> 32;
        bl  = {32'd0, b[31:0]};
        hi  = ah * bh;
        mid = ah * bl + al * bh;
        lo  = al * bl;
        return (hi << 4) + ((mid + (lo >> 32)) >> 28);
    endfunction

    // Entry k holds round(2^FRAC_BITS * f(8k/TABLE_ENTRIES)), f = sigmoid or tanh.
    // e^-x is stepped as powers of e^-(8/TABLE_ENTRIES) in 60-bit fixed point.
    function automatic tab_t build_tab(input logic is_tanh);
        tab_t        tab;
        logic [63:0] d;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] e36;
        logic [63:0] den;
        logic [63:0] e2;
        logic [63:0] den2;
        logic [63:0] one60;
        logic [63:0] one36;
        logic [63:0] q;
        one60 = 64'd1 << 60;
        one36 = 64'd1 << 36;
        d     = udiv64(64'd1 << 63, 64'(TABLE_ENTRIES));
        r     = one60;
        term  = one60;
        e     = one60;
        for (int n = 1; n <= 24; n++)
        begin
            term = udiv64(mul60(term, d), 64'(n));
            if (n % 2 == 1)
            begin
                r = r - term;
            end
            else
            begin
                r = r + term;
            end
        end
        for (int k = 0; k <= TABLE_ENTRIES; k++)
        begin
            e36  = e >> 24;
            den  = one36 + e36;
            e2   = mul60(e, e) >> 24;
            den2 = one36 + e2;
            if (is_tanh)
            begin
                q = udiv64(((one36 - e2) << FRAC_BITS) + (den2 >> 1), den2);
            end
            else
            begin
                q = udiv64((64'd1 << (36 + FRAC_BITS)) + (den >> 1), den);
            end
            tab[k] = tab_entry_t'(q);
            e      = mul60(e, r);
        end
        return tab;
    endfunction

    localparam tab_t SIG_TAB  = build_tab(1'b0);
    localparam tab_t TANH_TAB = build_tab(1'b1);

endpackage

@@ hw/rtl/afu_in_if.sv @@
interface afu_in_if;
    logic           valid;
    logic           ready;
    afu_pkg::data_t sample;
    logic           last_element;

    modport source (output valid, output sample, output last_element, input ready);
    modport sink   (input valid, input sample, input last_element, output ready);
endinterface

@@ hw/rtl/afu_out_if.sv @@
interface afu_out_if;
    logic           valid;
    logic           ready;
    afu_pkg::data_t value;
    logic           saturated;
    logic           last_out;

    modport source (output valid, output value, output saturated, output last_out, input ready);
    modport sink   (input valid, input value, input saturated, input last_out, output ready);
endinterface

@@ hw/rtl/afu_lookup.sv @@
// Table address generation and read of the two neighboring entries.
module afu_lookup (
    input  afu_pkg::func_t    func,
    input  afu_pkg::mag_t     mag,
    output afu_pkg::lut_row_t row
);

    afu_pkg::pidx_t     p;
    afu_pkg::pidx_t     idx_full;
    logic               beyond;
    logic               use_sig;
    afu_pkg::idx_t      lo_idx;
    afu_pkg::idx_t      hi_idx;
    afu_pkg::tab_entry_t lo;
    afu_pkg::tab_entry_t hi;

    // span is 8 << FRAC_BITS, so the divide is a shift and the remainder a mask
    assign p        = afu_pkg::pidx_t'(mag) * afu_pkg::pidx_t'(afu_pkg::TABLE_ENTRIES);
    assign idx_full = p >> afu_pkg::SPAN_SHIFT;
    assign beyond   = idx_full >= afu_pkg::pidx_t'(afu_pkg::TABLE_ENTRIES);

    // past |x| = 8 both reads land on the last entry, so the slope is zero
    assign lo_idx = beyond ? afu_pkg::idx_t'(afu_pkg::TABLE_ENTRIES)
                           : idx_full[afu_pkg::IDX_W-1:0];
    assign hi_idx = beyond ? afu_pkg::idx_t'(afu_pkg::TABLE_ENTRIES)
                           : idx_full[afu_pkg::IDX_W-1:0] + afu_pkg::idx_t'(1);

    assign use_sig = (func == afu_pkg::FN_SIGMOID) || (func == afu_pkg::FN_SIGMOID_GRAD);

    assign lo = use_sig ? afu_pkg::SIG_TAB[lo_idx] : afu_pkg::TANH_TAB[lo_idx];
    assign hi = use_sig ? afu_pkg::SIG_TAB[hi_idx] : afu_pkg::TANH_TAB[hi_idx];

    always_comb
    begin
        row.lo   = lo;
        row.diff = hi - lo;
        row.rem  = p[afu_pkg::REM_W-1:0];
    end

endmodule

@@ hw/rtl/activation_function_unit_top.sv @@
// Activation unit: one signed Q8.16 sample per beat in, one Q8.16 result per beat out, in
// order. The datapath is a six-register pipeline (table read, interpolation, square or
// s*(1-s) product, operand select, scale product, round/clip into the output register), so
// each sample moves through all six registers in order, and a new sample is
// taken every cycle while the result side keeps up. samples.ready drops only when all six
// stages hold data and the result beat is refused. The function is chosen by register 0;
// registers 1 to 3 hold the leak slope and the sigmoid and tanh scales. Write them only while
// no sample is in flight. Codes 6 and 7 pass the sample through unchanged.
module activation_function_unit_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [afu_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [afu_pkg::CFG_DATA_W-1:0]     cfg_data,
    afu_in_if.sink                             samples,
    afu_out_if.source                          results
);

    // Configuration registers
    afu_pkg::func_t                   func_reg;
    logic [afu_pkg::LEAK_W-1:0]       leak_reg;
    logic [afu_pkg::SIG_SCALE_W-1:0]  sig_scale_reg;
    afu_pkg::data_t                   tanh_scale_reg;

    // Pipeline control
    logic [afu_pkg::STAGES:1] vld_reg;
    logic [afu_pkg::STAGES:1] adv;

    // Stage payloads
    afu_pkg::data_t      x1_reg, x2_reg, x3_reg, x4_reg, x5_reg;
    logic                last1_reg, last2_reg, last3_reg, last4_reg, last5_reg;
    afu_pkg::lut_row_t   row1_reg;
    afu_pkg::tab_entry_t f2_reg, f3_reg;
    afu_pkg::m1_t        m1_3_reg;
    afu_pkg::op_t        op4_reg;
    afu_pkg::coef_t      coef4_reg;
    afu_pkg::prod_t      prod5_reg;
    afu_pkg::data_t      value_reg;
    logic                sat_reg;
    logic                last6_reg;

    // Next values
    afu_pkg::mag_t       mag;
    afu_pkg::lut_row_t   row1_next;
    afu_pkg::ip_t        ip;
    afu_pkg::tab_entry_t f2_next;
    afu_pkg::tab_entry_t m1_b;
    afu_pkg::m1_t        m1_3_next;
    afu_pkg::m1_t        g_full;
    afu_pkg::tab_entry_t g;
    afu_pkg::op_t        f_op;
    afu_pkg::op_t        op4_next;
    afu_pkg::coef_t      coef4_next;
    afu_pkg::prod_t      prod5_next;
    afu_pkg::y_t         sum_leak;
    afu_pkg::y_t         sum_frac;
    afu_pkg::y_t         y_leak;
    afu_pkg::y_t         y_frac;
    afu_pkg::y_t         y;
    logic                x5_pos;
    afu_pkg::data_t      value_next;
    logic                sat_next;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg       <= afu_pkg::FN_RELU;
            leak_reg       <= '0;
            sig_scale_reg  <= afu_pkg::SIG_SCALE_W'(afu_pkg::SIG_SCALE_RESET);
            tanh_scale_reg <= afu_pkg::data_t'(afu_pkg::TANH_SCALE_RESET);
        end
        else if (cfg_write)
        begin
            unique case (afu_pkg::cfg_reg_t'(cfg_index))
                afu_pkg::REG_FUNCTION_SELECT:
                    func_reg <= afu_pkg::func_t'(cfg_data[afu_pkg::FSEL_W-1:0]);
                afu_pkg::REG_LEAK_WEIGHT:
                    leak_reg <= cfg_data[afu_pkg::LEAK_W-1:0];
                afu_pkg::REG_SIGMOID_SCALE:
                    sig_scale_reg <= cfg_data[afu_pkg::SIG_SCALE_W-1:0];
                afu_pkg::REG_TANH_SCALE:
                    tanh_scale_reg <= afu_pkg::data_t'(cfg_data[afu_pkg::DATA_W-1:0]);
                default:
                    func_reg <= func_reg;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // a stage moves when it is empty or the stage after it moves
    always_comb
    begin
        adv[afu_pkg::STAGES] = !vld_reg[afu_pkg::STAGES] || results.ready;
        for (int i = afu_pkg::STAGES - 1; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                vld_reg[1] <= samples.valid;
            end
            for (int i = 2; i <= afu_pkg::STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign samples.ready = adv[1];

    // ---------------- stage 1: table read ----------------
    assign mag = samples.sample[afu_pkg::DATA_W-1] ? afu_pkg::mag_t'(~samples.sample + 1'b1)
                                                    : afu_pkg::mag_t'(samples.sample);

    afu_lookup u_lookup (
        .func (func_reg),
        .mag  (mag),
        .row  (row1_next)
    );

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            x1_reg    <= samples.sample;
            last1_reg <= samples.last_element;
            row1_reg  <= row1_next;
        end
    end

    // ---------------- stage 2: interpolation ----------------
    assign ip      = afu_pkg::ip_t'(row1_reg.diff) * afu_pkg::ip_t'(row1_reg.rem)
                     + afu_pkg::IP_HALF;
    assign f2_next = row1_reg.lo + afu_pkg::tab_entry_t'(ip >> afu_pkg::SPAN_SHIFT);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            x2_reg    <= x1_reg;
            last2_reg <= last1_reg;
            f2_reg    <= f2_next;
        end
    end

    // ---------------- stage 3: s*(1-s) or t*t ----------------
    assign m1_b      = (func_reg == afu_pkg::FN_SIGMOID_GRAD) ? afu_pkg::TAB_ONE - f2_reg
                                                              : f2_reg;
    assign m1_3_next = afu_pkg::m1_t'(f2_reg) * afu_pkg::m1_t'(m1_b);

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            x3_reg    <= x2_reg;
            last3_reg <= last2_reg;
            f3_reg    <= f2_reg;
            m1_3_reg  <= m1_3_next;
        end
    end

    // ---------------- stage 4: operand and scale select ----------------
    assign g_full = (m1_3_reg + afu_pkg::M1_HALF) >> afu_pkg::FRAC_BITS;
    assign g      = afu_pkg::tab_entry_t'(g_full);
    assign f_op   = {{(afu_pkg::OP_W - afu_pkg::TAB_W){1'b0}}, f3_reg};

    always_comb
    begin
        op4_next   = '0;
        coef4_next = '0;
        unique case (func_reg)
            afu_pkg::FN_RELU:
            begin
                op4_next   = afu_pkg::op_t'(x3_reg);
                coef4_next = {{(afu_pkg::COEF_W - afu_pkg::LEAK_W){1'b0}}, leak_reg};
            end
            afu_pkg::FN_RELU_GRAD:
            begin
                // leak rescaled from Q0.16 through the same round/shift path
                op4_next   = afu_pkg::OP_ONE;
                coef4_next = {{(afu_pkg::COEF_W - afu_pkg::LEAK_W){1'b0}}, leak_reg};
            end
            afu_pkg::FN_SIGMOID:
            begin
                op4_next   = x3_reg[afu_pkg::DATA_W-1] ? afu_pkg::OP_ONE - f_op : f_op;
                coef4_next = {{(afu_pkg::COEF_W - afu_pkg::SIG_SCALE_W){1'b0}}, sig_scale_reg};
            end
            afu_pkg::FN_SIGMOID_GRAD:
            begin
                op4_next   = {{(afu_pkg::OP_W - afu_pkg::TAB_W){1'b0}}, g};
                coef4_next = {{(afu_pkg::COEF_W - afu_pkg::SIG_SCALE_W){1'b0}}, sig_scale_reg};
            end
            afu_pkg::FN_TANH:
            begin
                op4_next   = x3_reg[afu_pkg::DATA_W-1] ? -f_op : f_op;
                coef4_next = afu_pkg::coef_t'(tanh_scale_reg);
            end
            afu_pkg::FN_TANH_GRAD:
            begin
                op4_next   = afu_pkg::OP_ONE - {{(afu_pkg::OP_W - afu_pkg::TAB_W){1'b0}}, g};
                coef4_next = afu_pkg::coef_t'(tanh_scale_reg);
            end
            default:
            begin
                op4_next   = '0;
                coef4_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            x4_reg    <= x3_reg;
            last4_reg <= last3_reg;
            op4_reg   <= op4_next;
            coef4_reg <= coef4_next;
        end
    end

    // ---------------- stage 5: scale product ----------------
    assign prod5_next = afu_pkg::prod_t'(op4_reg) * afu_pkg::prod_t'(coef4_reg);

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            x5_reg    <= x4_reg;
            last5_reg <= last4_reg;
            prod5_reg <= prod5_next;
        end
    end

    // ---------------- stage 6: round half up, clip ----------------
    assign sum_leak = afu_pkg::y_t'(prod5_reg) + afu_pkg::Y_HALF_LEAK;
    assign sum_frac = afu_pkg::y_t'(prod5_reg) + afu_pkg::Y_HALF_FRAC;
    assign y_leak   = sum_leak >>> afu_pkg::LEAK_FRAC;
    assign y_frac   = sum_frac >>> afu_pkg::FRAC_BITS;
    assign x5_pos   = !x5_reg[afu_pkg::DATA_W-1] && (x5_reg != '0);

    always_comb
    begin
        unique case (func_reg)
            afu_pkg::FN_RELU:         y = x5_pos ? afu_pkg::y_t'(x5_reg) : y_leak;
            afu_pkg::FN_RELU_GRAD:    y = x5_pos ? afu_pkg::Y_ONE : y_leak;
            afu_pkg::FN_SIGMOID,
            afu_pkg::FN_SIGMOID_GRAD,
            afu_pkg::FN_TANH,
            afu_pkg::FN_TANH_GRAD:    y = y_frac;
            default:                  y = afu_pkg::y_t'(x5_reg);
        endcase
    end

    always_comb
    begin
        priority if (y > afu_pkg::Y_MAX)
        begin
            value_next = afu_pkg::DATA_MAX;
            sat_next   = 1'b1;
        end
        else if (y < afu_pkg::Y_MIN)
        begin
            value_next = afu_pkg::DATA_MIN;
            sat_next   = 1'b1;
        end
        else
        begin
            value_next = afu_pkg::data_t'(y);
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            value_reg <= value_next;
            sat_reg   <= sat_next;
            last6_reg <= last5_reg;
        end
    end

    assign results.valid     = vld_reg[afu_pkg::STAGES];
    assign results.value     = value_reg;
    assign results.saturated = sat_reg;
    assign results.last_out  = last6_reg;

`ifndef SYNTHESIS
    // a clipped result sits exactly on a rail
    a_sat_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.saturated |->
            (results.value == afu_pkg::DATA_MAX) || (results.value == afu_pkg::DATA_MIN))
        else $error("saturated result not at a rail");

    // input back-pressure only comes from a full pipe facing a refused result beat
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> results.valid && !results.ready)
        else $error("input stalled without output back-pressure");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !results.valid |-> samples.ready)
        else $error("input not ready while output stage empty");

    // first stage only fills from an accepted sample
    a_fill_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(vld_reg[1]) |-> $past(samples.valid && samples.ready))
        else $error("stage 1 filled without an accepted sample");
`endif

endmodule
